/* hw/rtl/sidiv_pkg.sv */
// Shared types and constants for the saturating signed integer divider.
// No dependencies; used by signed_int_divider_saturating_top.
package sidiv_pkg;

    // Sequencer states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    // m_tuser layout, lowest bit first
    localparam int unsigned TUSER_W   = 2;
    localparam int unsigned TUSER_OVF = 0;
    localparam int unsigned TUSER_DZ  = 1;

endpackage

/* hw/rtl/signed_int_divider_saturating_top.sv */
// Saturating signed integer divider, radix-2 restoring, one quotient bit per cycle.
// Depends on sidiv_pkg (state type, m_tuser bit positions).

// Divides a signed DATA_WIDTH-bit dividend by a signed DATA_WIDTH-bit divisor and returns
// the quotient truncated toward zero. Operands are converted to magnitudes when the input
// transaction is accepted, and a single shift-and-subtract unit then retires one quotient
// bit per clock. After the last bit, once the output register is free, the combined sign
// is applied and the result is written to the output register. One division is in flight
// at a time, so a new transaction is accepted only once the current result has been
// written to the output register. s_tready is high whenever the unit is idle, even if a
// finished result is still waiting in the output register. The unit stalls on its final
// step only when that register is still occupied.
// Special cases: a zero divisor gives quotient 0 with div_by_zero set. The most negative
// value divided by -1 saturates to the positive maximum with overflow set.
// s_tdata : [DATA_WIDTH-1:0] dividend, [2*DATA_WIDTH-1:DATA_WIDTH] divisor, zero padded
// m_tdata : [DATA_WIDTH-1:0] quotient, zero padded
// m_tuser : [0] overflow, [1] div_by_zero
module signed_int_divider_saturating_top #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input channel
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,  // dividend, divisor
    // result channel
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]        m_tdata,  // quotient
    output logic [sidiv_pkg::TUSER_W-1:0]          m_tuser   // overflow, div_by_zero
);

    localparam int unsigned M_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int unsigned CNT_W     = $clog2(DATA_WIDTH + 1);

    localparam logic [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [CNT_W-1:0]      CNT_FULL = CNT_W'(DATA_WIDTH);

    // Control state
    sidiv_pkg::state_t         state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      m_tvalid_reg, m_tvalid_next;

    // Datapath: num_reg shifts dividend bits out at the top and quotient bits in at the bottom
    logic [DATA_WIDTH-1:0]     num_reg, num_next;
    logic [DATA_WIDTH-1:0]     rem_reg, rem_next;
    logic [DATA_WIDTH-1:0]     den_reg, den_next;
    logic                      neg_reg, neg_next;
    logic                      dz_reg, dz_next;
    logic [DATA_WIDTH-1:0]     quot_reg, quot_next;
    logic [sidiv_pkg::TUSER_W-1:0] user_reg, user_next;

    logic                      s_fire;
    logic                      out_free;
    logic [DATA_WIDTH-1:0]     dividend, divisor;
    logic [DATA_WIDTH-1:0]     dividend_mag, divisor_mag;
    logic [DATA_WIDTH+1:0]     diff;
    logic                      borrow;
    logic [DATA_WIDTH-1:0]     q_neg;

    assign dividend = s_tdata[DATA_WIDTH-1:0];
    assign divisor  = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

    assign dividend_mag = dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
    assign divisor_mag  = divisor[DATA_WIDTH-1]  ? (~divisor + 1'b1)  : divisor;

    assign s_tready = (state_reg == sidiv_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Restoring step: shifted partial remainder minus divisor; borrow means restore
    assign diff   = {1'b0, rem_reg, num_reg[DATA_WIDTH-1]} - {2'b00, den_reg};
    assign borrow = diff[DATA_WIDTH+1];
    assign q_neg  = ~num_reg + 1'b1;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        neg_next      = neg_reg;
        dz_next       = dz_reg;
        quot_next     = quot_reg;
        user_next     = user_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            sidiv_pkg::ST_IDLE: begin
                if (s_fire) begin
                    num_next   = dividend_mag;
                    den_next   = divisor_mag;
                    rem_next   = '0;
                    neg_next   = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
                    dz_next    = (divisor == '0);
                    count_next = CNT_FULL;
                    state_next = sidiv_pkg::ST_RUN;
                end
            end
            sidiv_pkg::ST_RUN: begin
                if (count_reg != '0) begin
                    if (!borrow) begin
                        rem_next = diff[DATA_WIDTH-1:0];
                    end else begin
                        rem_next = {rem_reg[DATA_WIDTH-2:0], num_reg[DATA_WIDTH-1]};
                    end
                    num_next   = {num_reg[DATA_WIDTH-2:0], !borrow};
                    count_next = count_reg - 1'b1;
                end else if (out_free) begin
                    // Apply sign, saturate, publish
                    user_next = '0;
                    if (dz_reg) begin
                        quot_next = '0;
                        user_next[sidiv_pkg::TUSER_DZ] = 1'b1;
                    end else if (neg_reg) begin
                        quot_next = q_neg;
                    end else if (num_reg[DATA_WIDTH-1]) begin
                        quot_next = SMAX;
                        user_next[sidiv_pkg::TUSER_OVF] = 1'b1;
                    end else begin
                        quot_next = num_reg;
                    end
                    m_tvalid_next = 1'b1;
                    state_next    = sidiv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sidiv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sidiv_pkg::ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        dz_reg   <= dz_next;
        quot_reg <= quot_next;
        user_reg <= user_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(quot_reg);
    assign m_tuser  = user_reg;

endmodule

/* test/signed_int_divider_saturating_top_tb.sv */
// Self-checking testbench for signed_int_divider_saturating_top.
// Depends on sidiv_pkg (m_tuser bit positions) and the divider RTL.
// Covers directed corner operands, random traffic, random idling and one long output stall.
module signed_int_divider_saturating_top_tb;

    localparam int unsigned DW          = 32;
    localparam int unsigned S_W         = ((2*DW+7)/8)*8;
    localparam int unsigned M_W         = ((DW+7)/8)*8;
    localparam int unsigned N_RANDOM    = 530;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned HOLD_AFTER  = 110;   // accepted inputs before the long stall
    localparam int unsigned MAX_GAP     = 18;
    localparam int unsigned LIMIT       = 400000;

    localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] ONE  = {{(DW-1){1'b0}}, 1'b1};
    localparam logic [DW-1:0] NEG1 = {DW{1'b1}};

    // One pending division and the idle cycles the sender spends before offering it
    typedef struct {
        logic [DW-1:0] dividend;
        logic [DW-1:0] divisor;
        int unsigned   gap;
    } div_op_t;

    typedef struct {
        logic [DW-1:0] quotient;
        logic          overflow;
        logic          div_by_zero;
    } quot_res_t;

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata  = '0;   // [DW-1:0] dividend, [2*DW-1:DW] divisor
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;         // [DW-1:0] quotient
    logic [sidiv_pkg::TUSER_W-1:0] m_tuser;     // [0] overflow, [1] div_by_zero

    div_op_t     div_op_q[$];        // operations waiting to be offered
    quot_res_t   quot_exp_q[$];      // predicted quotients, oldest first
    logic        in_fire   = 1'b0;   // input transaction at the last rising edge
    logic        out_fire  = 1'b0;   // result transaction at the last rising edge
    int unsigned in_cnt    = 0;
    int unsigned res_cnt   = 0;
    int unsigned err_cnt   = 0;
    int unsigned cycle_cnt = 0;
    int unsigned wait_cnt  = 0;      // sender idle cycles spent on the current gap
    int unsigned stall_cnt = 0;      // receiver stall cycles left
    int unsigned hold_cnt  = 0;      // long receiver hold-off, counted at the rising edge
    logic        hold_req  = 1'b0;

    signed_int_divider_saturating_top #(
        .DATA_WIDTH (DW)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Truncating signed division on magnitudes, sign applied afterwards.
    // Only a positive quotient can exceed the signed maximum (most negative over minus one).
    function automatic quot_res_t divide_saturate(logic [DW-1:0] num, logic [DW-1:0] den);
        quot_res_t     r;
        logic          neg_n;
        logic          neg_d;
        logic [DW-1:0] mag_n;
        logic [DW-1:0] mag_d;
        logic [DW-1:0] q;
        neg_n = num[DW-1];
        neg_d = den[DW-1];
        mag_n = neg_n ? -num : num;
        mag_d = neg_d ? -den : den;
        r.quotient    = '0;
        r.overflow    = 1'b0;
        r.div_by_zero = 1'b0;
        if (mag_d == '0) begin
            r.div_by_zero = 1'b1;
        end else begin
            q = mag_n / mag_d;
            if (neg_n != neg_d) begin
                r.quotient = -q;
            end else if (q > SMAX) begin
                r.quotient = SMAX;
                r.overflow = 1'b1;
            end else begin
                r.quotient = q;
            end
        end
        return r;
    endfunction

    function automatic void add_op(logic [DW-1:0] dividend, logic [DW-1:0] divisor,
                                   int unsigned gap);
        div_op_t op;
        op.dividend = dividend;
        op.divisor  = divisor;
        op.gap      = gap;
        div_op_q.push_back(op);
    endfunction

    // Sender: waits out the item's gap, then holds tvalid until the transaction completes.
    // Only one nonblocking write per signal per falling edge, so back-to-back items keep
    // tvalid high.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (div_op_q.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (wait_cnt < div_op_q[0].gap) begin
                s_tvalid <= 1'b0;
                wait_cnt++;
            end else begin
                s_tdata  <= {div_op_q[0].divisor, div_op_q[0].dividend};
                s_tvalid <= 1'b1;
                wait_cnt = 0;
                void'(div_op_q.pop_front());
            end
        end
    end

    // Receiver: draws a stall after each result; every third block of 64 results runs with
    // tready held high. The long hold-off overrides both.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (out_fire)
                stall_cnt = ((res_cnt / 64) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_cnt != 0) begin
                m_tready <= 1'b0;
            end else if (stall_cnt != 0) begin
                m_tready <= 1'b0;
                stall_cnt--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Long hold-off so the divider fills its output register and drops s_tready
    always @(posedge aclk) begin
        if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else if (hold_req)
            hold_cnt <= HOLD_CYCLES;
    end

    // Monitor: predicts on every input transaction, checks every result transaction
    always @(posedge aclk) begin
        quot_res_t exp_res;
        cycle_cnt <= cycle_cnt + 1;
        in_fire   <= aresetn && s_tvalid && s_tready;
        out_fire  <= aresetn && m_tvalid && m_tready;
        if (cycle_cnt > LIMIT) begin
            $display("signed_int_divider_saturating_top_tb: FAIL");
            $finish;
        end else if (aresetn) begin
            if (m_tvalid && m_tready) begin
                res_cnt <= res_cnt + 1;
                if (quot_exp_q.size() == 0) begin
                    $error("result with no pending operation: quotient %0d",
                           $signed(m_tdata[DW-1:0]));
                    err_cnt++;
                end else begin
                    exp_res = quot_exp_q.pop_front();
                    if (m_tdata[DW-1:0] !== exp_res.quotient) begin
                        $error("quotient: expected %0d, got %0d",
                               $signed(exp_res.quotient), $signed(m_tdata[DW-1:0]));
                        err_cnt++;
                    end
                    if (m_tuser[sidiv_pkg::TUSER_OVF] !== exp_res.overflow) begin
                        $error("overflow: expected %0b, got %0b",
                               exp_res.overflow, m_tuser[sidiv_pkg::TUSER_OVF]);
                        err_cnt++;
                    end
                    if (m_tuser[sidiv_pkg::TUSER_DZ] !== exp_res.div_by_zero) begin
                        $error("div_by_zero: expected %0b, got %0b",
                               exp_res.div_by_zero, m_tuser[sidiv_pkg::TUSER_DZ]);
                        err_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                in_cnt <= in_cnt + 1;
                quot_exp_q.push_back(divide_saturate(s_tdata[DW-1:0], s_tdata[2*DW-1:DW]));
            end
        end
    end

    initial begin
        logic [DW-1:0] num;
        logic [DW-1:0] den;
        int unsigned   gap;
        int unsigned   idx;

        // Directed corners: zero divisor, the saturating pair, extremes, all sign combinations
        add_op('0,              '0,               0);
        add_op(SMAX,            '0,               0);
        add_op(SMIN,            '0,               0);
        add_op(SMIN,            NEG1,             0);
        add_op(SMIN,            ONE,              3);
        add_op(SMAX,            NEG1,             0);
        add_op(SMAX,            ONE,              7);
        add_op(SMIN,            SMIN,             0);
        add_op(SMAX,            SMAX,             1);
        add_op(SMIN,            SMAX,             0);
        add_op(SMAX,            SMIN,             12);
        add_op(DW'(7),          DW'(2),           0);
        add_op(-DW'(7),         DW'(2),           0);
        add_op(DW'(7),          -DW'(2),          5);
        add_op(-DW'(7),         -DW'(2),          0);
        add_op(ONE,             SMIN,             0);
        add_op(NEG1,            SMIN,             18);
        add_op('0,              DW'(5),           0);
        add_op(DW'(5),          DW'(7),           2);
        add_op(DW'(100),        NEG1,             0);
        add_op(NEG1,            NEG1,             0);
        add_op(SMIN + ONE,      NEG1,             9);

        // Random traffic: gap-free stretches every fourth block of 50 and around the hold-off
        for (idx = 0; idx < N_RANDOM; idx++) begin
            num = $urandom;
            den = $urandom;
            case ($urandom_range(0, 9))
                0: den = '0;
                1: begin
                    num = SMIN;
                    if ($urandom_range(0, 1))
                        den = NEG1;
                end
                2: den = DW'($urandom_range(1, 16));
                3: den = den >> $urandom_range(0, DW-1);
                4: num = DW'($urandom_range(0, 100));
                default: ;
            endcase
            if (den != '0 && $urandom_range(0, 3) == 0)
                den = -den;
            if ((idx / 50) % 4 == 1 || (idx >= HOLD_AFTER - 30 && idx < HOLD_AFTER + 60))
                gap = 0;
            else
                gap = $urandom_range(0, MAX_GAP);
            add_op(num, den, gap);
        end

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // Keep the sender busy while the receiver refuses results for a long stretch
        while (in_cnt < HOLD_AFTER)
            @(negedge aclk);
        hold_req = 1'b1;
        while (hold_cnt == 0)
            @(negedge aclk);
        hold_req = 1'b0;

        while (div_op_q.size() != 0 || s_tvalid)
            @(negedge aclk);
        while (quot_exp_q.size() != 0)
            @(negedge aclk);
        // Drain window past the divider latency to catch stray results
        repeat (DW + 8) @(negedge aclk);

        if (err_cnt == 0)
            $display("signed_int_divider_saturating_top_tb: PASS");
        else
            $display("signed_int_divider_saturating_top_tb: FAIL");
        $finish;
    end

endmodule
